/* src/srct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package srct_pkg;

  localparam int CoordW = 24;
  localparam int OpW    = CoordW + 1;
  localparam int CntW   = $clog2(OpW);
  localparam int MaxClips = 4;

  // outcode bits
  localparam int OcAbove = 0;
  localparam int OcBelow = 1;
  localparam int OcRight = 2;
  localparam int OcLeft  = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT
  } clip_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_e;

  typedef struct packed {
    logic done;
    logic zero_div;
  } md_status_t;

  function automatic logic [OpW-1:0] mag(input logic signed [OpW-1:0] v);
    mag = v[OpW-1] ? OpW'(-v) : OpW'(v);
  endfunction

endpackage
`default_nettype wire

/* src/srct_muldiv.sv */
`timescale 1ns / 1ps
`default_nettype none
// Serial a*b/d on magnitudes, truncated toward zero; requires |a*b/d| < 2**OpW.
module srct_muldiv
  import srct_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic signed [OpW-1:0] a_i,
  input  wire logic signed [OpW-1:0] b_i,
  input  wire logic signed [OpW-1:0] d_i,
  output md_status_t                 status_o,
  output logic signed [OpW:0]        q_o
);

  md_state_e             state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [2*OpW-1:0]      prod_q, prod_d;
  logic [OpW-1:0]        mb_q, mb_d, md_q, md_d;
  logic                  neg_q, neg_d, zero_q, zero_d;

  logic [OpW:0]          sum;
  logic [OpW:0]          trial;
  logic                  ge;
  logic                  last;

  assign last = (cnt_q == CntW'(OpW - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: if (start_i) state_d = MD_MUL;
      MD_MUL:  if (last) state_d = MD_DIV;
      MD_DIV:  if (last) state_d = MD_DONE;
      MD_DONE: state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  // shift-add multiply, then restoring divide one bit per cycle
  always_comb begin
    cnt_d  = cnt_q;
    prod_d = prod_q;
    mb_d   = mb_q;
    md_d   = md_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    sum    = {1'b0, prod_q[2*OpW-1:OpW]} + (prod_q[0] ? {1'b0, mb_q} : '0);
    trial  = {prod_q[2*OpW-1:OpW], prod_q[OpW-1]};
    ge     = (trial >= {1'b0, md_q});
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          prod_d = {{OpW{1'b0}}, mag(a_i)};
          mb_d   = mag(b_i);
          md_d   = mag(d_i);
          neg_d  = a_i[OpW-1] ^ b_i[OpW-1] ^ d_i[OpW-1];
          zero_d = (d_i == '0);
          cnt_d  = '0;
        end
      end
      MD_MUL: begin
        prod_d = {sum, prod_q[OpW-1:1]};
        cnt_d  = last ? '0 : cnt_q + 1'b1;
      end
      MD_DIV: begin
        prod_d[2*OpW-1:OpW] = ge ? OpW'(trial - {1'b0, md_q}) : trial[OpW-1:0];
        prod_d[OpW-1:0]     = {prod_q[OpW-2:0], ge};
        cnt_d               = cnt_q + 1'b1;
      end
      MD_DONE: ;
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    status_o.done     = (state_q == MD_DONE);
    status_o.zero_div = zero_q;
    if (zero_q) q_o = '0;
    else if (neg_q) q_o = -$signed({1'b0, prod_q[OpW-1:0]});
    else q_o = $signed({1'b0, prod_q[OpW-1:0]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    mb_q   <= mb_d;
    md_q   <= md_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

endmodule
`default_nettype wire

/* src/segment_rectangle_clip_test.sv */
`timescale 1ns / 1ps
`default_nettype none
// Segment/window touch test by outcode clipping. Raise start with all eight
// coordinates; the item transfers when busy is low. Each pass checks both
// outcodes; each clip (up to four) adds a serial multiply and divide in the
// bit-serial multiply/divide unit before the next check. The answer is on
// touches_window_o for exactly one cycle with valid_o high and cannot be
// stalled; busy drops in that same cycle.
module segment_rectangle_clip_test
  import srct_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [CoordW-1:0] start_x_i,
  input  wire logic signed [CoordW-1:0] start_y_i,
  input  wire logic signed [CoordW-1:0] end_x_i,
  input  wire logic signed [CoordW-1:0] end_y_i,
  input  wire logic signed [CoordW-1:0] window_left_i,
  input  wire logic signed [CoordW-1:0] window_right_i,
  input  wire logic signed [CoordW-1:0] window_bottom_i,
  input  wire logic signed [CoordW-1:0] window_top_i,
  output logic                          valid_o,
  output logic                          touches_window_o
);

  clip_state_e state_q, state_d;
  logic signed [CoordW-1:0] x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic signed [CoordW-1:0] xl_q, xl_d, xr_q, xr_d, yb_q, yb_d, yt_q, yt_d;
  logic [2:0] clips_q, clips_d;
  logic       mv_x_q, mv_x_d;
  logic       valid_q, valid_d, touch_q, touch_d;

  logic [3:0] c0, c1, cs;
  logic signed [CoordW-1:0] px, py, qx, qy;
  logic decide;

  logic                  md_start;
  logic signed [OpW-1:0] md_a, md_b, md_d;
  md_status_t            md_st;
  logic signed [OpW:0]   md_q;
  logic signed [OpW+1:0] moved;

  function automatic logic [3:0] outcode(input logic signed [CoordW-1:0] x,
      input logic signed [CoordW-1:0] y, input logic signed [CoordW-1:0] l,
      input logic signed [CoordW-1:0] r, input logic signed [CoordW-1:0] b,
      input logic signed [CoordW-1:0] t);
    outcode          = '0;
    outcode[OcAbove] = (y > t);
    outcode[OcBelow] = (y < b);
    outcode[OcRight] = (x > r);
    outcode[OcLeft]  = (x < l);
  endfunction

  function automatic logic signed [OpW-1:0] sub(input logic signed [CoordW-1:0] a,
      input logic signed [CoordW-1:0] b);
    sub = OpW'(a) - OpW'(b);
  endfunction

  // classify both endpoints; put an outside point first
  always_comb begin
    c0 = outcode(x0_q, y0_q, xl_q, xr_q, yb_q, yt_q);
    c1 = outcode(x1_q, y1_q, xl_q, xr_q, yb_q, yt_q);
    decide = ((c0 & c1) != '0) || ((c0 | c1) == '0) || (clips_q >= 3'(MaxClips));
    if (c0 == '0) begin
      px = x1_q; py = y1_q; qx = x0_q; qy = y0_q; cs = c1;
    end else begin
      px = x0_q; py = y0_q; qx = x1_q; qy = y1_q; cs = c0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_CHECK;
      ST_CHECK: state_d = decide ? ST_IDLE : ST_WAIT;
      ST_WAIT:  if (md_st.done) state_d = ST_CHECK;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign moved = (mv_x_q ? (OpW+2)'(x0_q) : (OpW+2)'(y0_q)) + (OpW+2)'(md_q);

  // datapath and result
  always_comb begin
    x0_d = x0_q; y0_d = y0_q; x1_d = x1_q; y1_d = y1_q;
    xl_d = xl_q; xr_d = xr_q; yb_d = yb_q; yt_d = yt_q;
    clips_d  = clips_q;
    mv_x_d   = mv_x_q;
    valid_d  = 1'b0;
    touch_d  = touch_q;
    md_start = 1'b0;
    md_a = '0; md_b = '0; md_d = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          x0_d = start_x_i; y0_d = start_y_i; x1_d = end_x_i; y1_d = end_y_i;
          xl_d = window_left_i; xr_d = window_right_i;
          yb_d = window_bottom_i; yt_d = window_top_i;
          clips_d = '0;
        end
      end
      ST_CHECK: begin
        if (decide) begin
          valid_d = 1'b1;
          touch_d = ((c0 & c1) == '0) && ((c0 | c1) == '0);
        end else begin
          md_start = 1'b1;
          clips_d  = clips_q + 1'b1;
          x0_d = px; y0_d = py; x1_d = qx; y1_d = qy;
          if (cs[OcAbove] || cs[OcBelow]) begin
            mv_x_d = 1'b1;
            y0_d   = cs[OcAbove] ? yt_q : yb_q;
            md_a   = sub(qx, px);
            md_b   = sub(y0_d, py);
            md_d   = sub(qy, py);
          end else begin
            mv_x_d = 1'b0;
            x0_d   = cs[OcRight] ? xr_q : xl_q;
            md_a   = sub(qy, py);
            md_b   = sub(x0_d, px);
            md_d   = sub(qx, px);
          end
        end
      end
      ST_WAIT: begin
        if (md_st.done) begin
          if (mv_x_q) x0_d = moved[CoordW-1:0];
          else        y0_d = moved[CoordW-1:0];
        end
      end
      default: ;
    endcase
  end

  srct_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .d_i     (md_d),
    .status_o(md_st),
    .q_o     (md_q)
  );

  assign busy             = (state_q != ST_IDLE);
  assign valid_o          = valid_q;
  assign touches_window_o = touch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      clips_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      clips_q <= clips_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q <= x0_d; y0_q <= y0_d; x1_q <= x1_d; y1_q <= y1_d;
    xl_q <= xl_d; xr_q <= xr_d; yb_q <= yb_d; yt_q <= yt_d;
    mv_x_q  <= mv_x_d;
    touch_q <= touch_d;
  end

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import srct_pkg::*;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t sx, sy, ex, ey, wl, wr, wb, wt;
  } segment_t;

  localparam logic [3:0] OcAboveM = 4'(1 << OcAbove);
  localparam logic [3:0] OcBelowM = 4'(1 << OcBelow);
  localparam logic [3:0] OcRightM = 4'(1 << OcRight);
  localparam logic [3:0] OcLeftM  = 4'(1 << OcLeft);
  localparam int CycleLimit = 4000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  coord_t window_left_i = '0, window_right_i = '0, window_bottom_i = '0, window_top_i = '0;
  logic valid_o, touches_window_o;

  segment_t pending_q[$];
  logic     touch_q[$];
  int       hold_gap = 0;
  bit       drain_req = 1'b0;
  bit       stim_done = 1'b0;
  int       fails = 0;
  int       cycles = 0;

  always #5 clk_i = ~clk_i;

  segment_rectangle_clip_test i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .window_left_i, .window_right_i, .window_bottom_i, .window_top_i,
    .valid_o, .touches_window_o
  );

  function automatic logic [3:0] outcode(longint x, longint y, segment_t s);
    logic [3:0] c = '0;
    if (y > longint'(s.wt)) c |= OcAboveM;
    if (y < longint'(s.wb)) c |= OcBelowM;
    if (x > longint'(s.wr)) c |= OcRightM;
    if (x < longint'(s.wl)) c |= OcLeftM;
    return c;
  endfunction

  // p_other + (q_other - p_other) * (edge - p_edge) / (q_edge - p_edge), toward zero
  function automatic longint lerp(longint qo, longint po, longint edg, longint pe, longint qe);
    longint den = qe - pe;
    if (den == 0) return po;
    return po + ((qo - po) * (edg - pe)) / den;
  endfunction

  function automatic logic predict_touch(segment_t s);
    longint x0 = s.sx, y0 = s.sy, x1 = s.ex, y1 = s.ey, t;
    logic [3:0] c0, c1;
    int clips = 0;
    forever begin
      c0 = outcode(x0, y0, s);
      c1 = outcode(x1, y1, s);
      if ((c0 & c1) != 0) return 1'b0;
      if ((c0 | c1) == 0) return 1'b1;
      if (clips >= MaxClips) return 1'b0;
      if (c0 == 0) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
        c0 = c1;
      end
      if (c0 & OcAboveM) begin
        x0 = lerp(x1, x0, s.wt, y0, y1); y0 = s.wt;
      end else if (c0 & OcBelowM) begin
        x0 = lerp(x1, x0, s.wb, y0, y1); y0 = s.wb;
      end else if (c0 & OcRightM) begin
        y0 = lerp(y1, y0, s.wr, x0, x1); x0 = s.wr;
      end else begin
        y0 = lerp(y1, y0, s.wl, x0, x1); x0 = s.wl;
      end
      clips++;
    end
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
  endfunction

  // small offsets around a value, or anywhere at all
  function automatic coord_t near(coord_t base, int span);
    if ($urandom_range(0, 9) == 0) return coord_t'($urandom);
    return base + coord_t'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic segment_t rand_item();
    segment_t s;
    coord_t cx, cy;
    int w, h, mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      cx = coord_t'($urandom);
      cy = coord_t'($urandom);
      if (mode < 3) begin
        cx = cx >>> 4; cy = cy >>> 4;
      end
      w = $urandom_range(0, 4000);
      h = $urandom_range(0, 4000);
      s.wl = cx - coord_t'(w); s.wr = cx + coord_t'(w);
      s.wb = cy - coord_t'(h); s.wt = cy + coord_t'(h);
      if (mode == 9) begin
        s.wl = s.wr + 1;
      end
      s.sx = near(cx, 3 * w + 8); s.sy = near(cy, 3 * h + 8);
      s.ex = near(cx, 3 * w + 8); s.ey = near(cy, 3 * h + 8);
    end
    return s;
  endfunction

  task automatic push_item(segment_t s);
    pending_q.push_back(s);
  endtask

  // driver: one transfer per start while busy is low
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        touch_q.push_back(predict_touch({start_x_i, start_y_i, end_x_i, end_y_i,
                                         window_left_i, window_right_i,
                                         window_bottom_i, window_top_i}));
        void'(pending_q.pop_front());
        hold_gap = pick_gap();
      end
      if (!(start && busy)) begin
        if (hold_gap > 0 && !(start && !busy && hold_gap == 0)) hold_gap--;
        if (pending_q.size() > 0 && hold_gap == 0 && !(drain_req && touch_q.size() > 0)
            && !(start && !busy && pending_q.size() == 0)) begin
          start <= 1'b1;
          {start_x_i, start_y_i, end_x_i, end_y_i, window_left_i, window_right_i,
           window_bottom_i, window_top_i} <= pending_q[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (touch_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0b", $time, touches_window_o);
        fails++;
      end else begin
        if (touches_window_o !== touch_q[0]) begin
          $display("%0t: touches_window mismatch, expected %0b, actual %0b",
                   $time, touch_q[0], touches_window_o);
          fails++;
        end
        void'(touch_q.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    segment_t s;
    coord_t mx, mn;
    mx = coord_t'(24'h7fffff);
    mn = coord_t'(24'h800000);
    // inside, fully, on corners, at field extremes
    push_item('{0, 0, 100, 100, -256, 256, -256, 256});
    push_item('{-256, -256, 256, 256, -256, 256, -256, 256});
    push_item('{mn, mn, mx, mx, mn, mx, mn, mx});
    push_item('{mn, mn, mx, mx, -256, 256, -256, 256});
    push_item('{mx, mn, mn, mx, -256, 256, -256, 256});
    push_item('{mx, mx, mx, mn, -256, 256, -256, 256});
    // trivial rejects on each side
    push_item('{-100, 300, 100, 400, -256, 256, -256, 256});
    push_item('{-100, -300, 100, -400, -256, 256, -256, 256});
    push_item('{300, -100, 400, 100, -256, 256, -256, 256});
    push_item('{-300, -100, -400, 100, -256, 256, -256, 256});
    // clip through each edge, and a corner miss needing all clips
    push_item('{0, 0, 0, 1000, -256, 256, -256, 256});
    push_item('{0, 1000, 0, -1000, -256, 256, -256, 256});
    push_item('{1000, 0, -1000, 0, -256, 256, -256, 256});
    push_item('{-1000, 300, 300, -1000, -256, 256, -256, 256});
    push_item('{-1000, 250, 250, -1000, -256, 256, -256, 256});
    push_item('{-600, 1000, 1000, -600, -256, 256, -256, 256});
    // inverted windows, zero-size window
    push_item('{0, 0, 10, 10, 256, -256, -256, 256});
    push_item('{0, 0, 10, 10, -256, 256, 256, -256});
    push_item('{5, 5, 5, 5, 5, 5, 5, 5});
    push_item('{-10, 5, 10, 5, 5, 5, 5, 5});
    push_item('{mn, mx, mx, mn, 0, 0, 0, 0});
    for (int i = 0; i < 1050; i++) begin
      push_item(rand_item());
      if (i == 500) begin
        wait (pending_q.size() == 0);
        drain_req = 1'b1;
        wait (touch_q.size() == 0);
        drain_req = 1'b0;
      end
    end
    stim_done = 1'b1;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && pending_q.size() == 0 && !start);
    wait (touch_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
src/srct_pkg.sv
src/srct_muldiv.sv
src/segment_rectangle_clip_test.sv
dv/tb_top.sv
